// ----- src/wpo_pkg.sv -----
// ----------------------------------------------------------------------------
// wpo_pkg: shared types and constants for the water outflow step
// Fixed point formats, register indexes, reset values and the item and
// divider stage structs used by the top level and the divider pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpo_pkg;

  // Value format: signed Q4.FRAC_BITS
  localparam int FRAC_BITS  = 20;
  localparam int VAL_BITS   = FRAC_BITS + 4;

  // Coefficient formats, Q1.16; the minimum total flow uses the value format
  localparam int ATT_W      = 17;
  localparam int STR_W      = 18;
  localparam int MIN_W      = 22;
  localparam int COEF_SHIFT = 16;

  // Configuration port
  localparam int CFG_W      = 22;
  localparam int CFG_IDX_W  = 2;

  // Internal widths
  localparam int P_W        = VAL_BITS + 1;           // positive pressure term
  localparam int TA_W       = ATT_W + 1 + VAL_BITS;   // attenuation * old
  localparam int TB_W       = STR_W + P_W + 1;        // strength * pressure
  localparam int ACC_W      = TB_W + 1;
  localparam int SHIFT_W    = ACC_W - COEF_SHIFT;
  localparam int SUM_W      = VAL_BITS + 2;           // sum of four flows
  localparam int REM_W      = SUM_W;                  // divisor and remainder
  localparam int PROD_W     = 2 * VAL_BITS;
  localparam int MAG_W      = 2 * VAL_BITS - 1;
  localparam int LANES      = 4;

  localparam logic signed [VAL_BITS-1:0] VAL_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};
  localparam logic signed [VAL_BITS-1:0] VAL_MIN = {1'b1, {(VAL_BITS-1){1'b0}}};

  // Register reset values
  localparam logic [ATT_W-1:0]        ATT_RESET = ATT_W'(65208);
  localparam logic signed [STR_W-1:0] STR_RESET = STR_W'(16384);
  localparam logic signed [MIN_W-1:0] MIN_RESET =
    MIN_W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTENUATION    = 2'd0,
    REG_STRENGTH       = 2'd1,
    REG_MIN_TOTAL_FLOW = 2'd2
  } wpo_reg_t;

  // Input item
  typedef struct packed {
    logic                       clear;
    logic signed [VAL_BITS-1:0] center_terrain;
    logic signed [VAL_BITS-1:0] center_water;
    logic signed [VAL_BITS-1:0] east_level;
    logic signed [VAL_BITS-1:0] north_level;
    logic signed [VAL_BITS-1:0] west_level;
    logic signed [VAL_BITS-1:0] south_level;
    logic signed [VAL_BITS-1:0] old_east;
    logic signed [VAL_BITS-1:0] old_north;
    logic signed [VAL_BITS-1:0] old_west;
    logic signed [VAL_BITS-1:0] old_south;
  } wpo_in_t;

  // Result item
  typedef struct packed {
    logic signed [VAL_BITS-1:0] flow_east;
    logic signed [VAL_BITS-1:0] flow_north;
    logic signed [VAL_BITS-1:0] flow_west;
    logic signed [VAL_BITS-1:0] flow_south;
  } wpo_out_t;

  // One lane of the divider: partial remainder, numerator bits shifting out
  // while quotient bits shift in, result sign and quotient overflow
  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [VAL_BITS-1:0] bits;
    logic                neg;
    logic                ovf;
  } wpo_lane_t;

  typedef struct packed {
    logic [REM_W-1:0]        den;
    wpo_lane_t [LANES-1:0]   lane;
  } wpo_div_t;

endpackage

// ----- src/water_pipe_outflow_step.sv -----
// An item passes 33 registers from acceptance to result valid
// (8 front stages, 24 divider stages, 1 result register); one item per cycle unless the output stalls.
// The length is set by the divider, which resolves one quotient bit per stage.
// Ready runs combinationally back through every stage, so internal bubbles are filled.
// Reset (synchronous) empties the pipeline and restores attenuation,
// strength and minimum total flow to their default values.
// ----------------------------------------------------------------------------
// water_pipe_outflow_step: virtual pipe outflow update for one grid cell
// Pressure terms, attenuated flow update with rounding and saturation,
// minimum flow cut and scaling of the outflows down to the water depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module water_pipe_outflow_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wpo_pkg::wpo_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wpo_pkg::wpo_out_t                   out_data,
  input  logic                                cfg_write,
  input  logic [wpo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wpo_pkg::CFG_W-1:0]           cfg_data
);

  localparam int V       = wpo_pkg::VAL_BITS;
  localparam int N       = wpo_pkg::LANES;
  localparam int P_W     = wpo_pkg::P_W;
  localparam int TA_W    = wpo_pkg::TA_W;
  localparam int TB_W    = wpo_pkg::TB_W;
  localparam int ACC_W   = wpo_pkg::ACC_W;
  localparam int SHIFT_W = wpo_pkg::SHIFT_W;
  localparam int SUM_W   = wpo_pkg::SUM_W;
  localparam int REM_W   = wpo_pkg::REM_W;
  localparam int PROD_W  = wpo_pkg::PROD_W;
  localparam int MAG_W   = wpo_pkg::MAG_W;
  localparam int CS      = wpo_pkg::COEF_SHIFT;

  // Configuration registers
  logic [wpo_pkg::ATT_W-1:0]        att;
  logic signed [wpo_pkg::STR_W-1:0] str;
  logic signed [wpo_pkg::MIN_W-1:0] min_flow;

  always_ff @(posedge clk) begin
    if (rst) begin
      att      <= wpo_pkg::ATT_RESET;
      str      <= wpo_pkg::STR_RESET;
      min_flow <= wpo_pkg::MIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        wpo_pkg::REG_ATTENUATION:    att      <= cfg_data[wpo_pkg::ATT_W-1:0];
        wpo_pkg::REG_STRENGTH:       str      <= $signed(cfg_data[wpo_pkg::STR_W-1:0]);
        wpo_pkg::REG_MIN_TOTAL_FLOW: min_flow <= $signed(cfg_data[wpo_pkg::MIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // Stage valids and ready chain
  logic v1, v2, v3, v4, v5, v6, v7, v8;
  logic r1, r2, r3, r4, r5, r6, r7, r8;
  logic div_in_ready;

  assign r8 = !v8 || div_in_ready;
  assign r7 = !v7 || r8;
  assign r6 = !v6 || r7;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
      if (r7) v7 <= v6;
      if (r8) v8 <= v7;
    end
  end

  // Stage 1: centre level and positive pressure terms
  logic signed [V-1:0] lvl_in [N];
  logic signed [V-1:0] old_in [N];
  logic signed [V:0]   centre;
  logic signed [V+1:0] diff   [N];
  logic [P_W-1:0]      p_next [N];

  logic                s1_clear;
  logic signed [V-1:0] s1_water;
  logic signed [V-1:0] s1_old [N];
  logic [P_W-1:0]      s1_p   [N];

  assign lvl_in[0] = in_data.east_level;
  assign lvl_in[1] = in_data.north_level;
  assign lvl_in[2] = in_data.west_level;
  assign lvl_in[3] = in_data.south_level;
  assign old_in[0] = in_data.old_east;
  assign old_in[1] = in_data.old_north;
  assign old_in[2] = in_data.old_west;
  assign old_in[3] = in_data.old_south;

  always_comb begin
    centre = (V+1)'(in_data.center_terrain) + (V+1)'(in_data.center_water);
    for (int i = 0; i < N; i++) begin
      diff[i]   = (V+2)'(centre) - (V+2)'(lvl_in[i]);
      p_next[i] = diff[i][V+1] ? '0 : diff[i][V:0];
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_clear <= in_data.clear;
      s1_water <= in_data.center_water;
      for (int i = 0; i < N; i++) begin
        s1_old[i] <= old_in[i];
        s1_p[i]   <= p_next[i];
      end
    end
  end

  // Stage 2: coefficient products
  logic                   s2_clear;
  logic signed [V-1:0]    s2_water;
  logic signed [TA_W-1:0] s2_ta [N];
  logic signed [TB_W-1:0] s2_tb [N];

  always_ff @(posedge clk) begin
    if (r2) begin
      s2_clear <= s1_clear;
      s2_water <= s1_water;
      for (int i = 0; i < N; i++) begin
        s2_ta[i] <= $signed({1'b0, att}) * s1_old[i];
        s2_tb[i] <= str * $signed({1'b0, s1_p[i]});
      end
    end
  end

  // Stage 3: round, shift and saturate each flow
  logic signed [ACC_W-1:0]   acc [N];
  logic signed [SHIFT_W-1:0] shv [N];
  logic signed [V-1:0]       flow_next [N];

  logic                s3_clear;
  logic signed [V-1:0] s3_water;
  logic signed [V-1:0] s3_flow [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      acc[i] = ACC_W'(s2_ta[i]) + ACC_W'(s2_tb[i]) + (ACC_W'(1) << (CS - 1));
      shv[i] = $signed(acc[i][ACC_W-1:CS]);
      if (shv[i] > SHIFT_W'(wpo_pkg::VAL_MAX)) begin
        flow_next[i] = wpo_pkg::VAL_MAX;
      end else if (shv[i] < SHIFT_W'(wpo_pkg::VAL_MIN)) begin
        flow_next[i] = wpo_pkg::VAL_MIN;
      end else begin
        flow_next[i] = shv[i][V-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      s3_clear <= s2_clear;
      s3_water <= s2_water;
      for (int i = 0; i < N; i++) begin
        s3_flow[i] <= flow_next[i];
      end
    end
  end

  // Stage 4: total outflow
  logic                    s4_clear;
  logic signed [V-1:0]     s4_water;
  logic signed [V-1:0]     s4_flow [N];
  logic signed [SUM_W-1:0] s4_total;

  always_ff @(posedge clk) begin
    if (r4) begin
      s4_clear <= s3_clear;
      s4_water <= s3_water;
      s4_total <= SUM_W'(s3_flow[0]) + SUM_W'(s3_flow[1])
                + SUM_W'(s3_flow[2]) + SUM_W'(s3_flow[3]);
      for (int i = 0; i < N; i++) begin
        s4_flow[i] <= s3_flow[i];
      end
    end
  end

  // Stage 5: choose zero, pass or scale; pass divides by one
  logic                above_min;
  logic                scale;
  logic                zero_all;
  logic [REM_W-1:0]    total_mag;

  logic signed [V-1:0] s5_flow [N];
  logic signed [V-1:0] s5_wsel;
  logic [REM_W-1:0]    s5_den;
  logic                s5_tneg;

  always_comb begin
    above_min = s4_total > SUM_W'(min_flow);
    scale     = SUM_W'(s4_water) < s4_total;
    zero_all  = s4_clear || !above_min || (scale && (s4_total == '0));
    total_mag = s4_total[SUM_W-1] ? REM_W'(-s4_total) : REM_W'(s4_total);
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      for (int i = 0; i < N; i++) begin
        s5_flow[i] <= s4_flow[i];
      end
      if (zero_all) begin
        s5_wsel <= '0;
        s5_den  <= REM_W'(1);
        s5_tneg <= 1'b0;
      end else if (scale) begin
        s5_wsel <= s4_water;
        s5_den  <= total_mag;
        s5_tneg <= s4_total[SUM_W-1];
      end else begin
        s5_wsel <= V'(1);
        s5_den  <= REM_W'(1);
        s5_tneg <= 1'b0;
      end
    end
  end

  // Stage 6: numerators
  logic signed [PROD_W-1:0] s6_prod [N];
  logic [REM_W-1:0]         s6_den;
  logic                     s6_tneg;

  always_ff @(posedge clk) begin
    if (r6) begin
      s6_den  <= s5_den;
      s6_tneg <= s5_tneg;
      for (int i = 0; i < N; i++) begin
        s6_prod[i] <= s5_flow[i] * s5_wsel;
      end
    end
  end

  // Stage 7: numerator magnitudes and result signs
  logic [MAG_W-1:0] s7_mag [N];
  logic             s7_neg [N];
  logic [REM_W-1:0] s7_den;

  always_ff @(posedge clk) begin
    if (r7) begin
      s7_den <= s6_den;
      for (int i = 0; i < N; i++) begin
        s7_mag[i] <= s6_prod[i][PROD_W-1] ? MAG_W'(-s6_prod[i]) : MAG_W'(s6_prod[i]);
        s7_neg[i] <= s6_prod[i][PROD_W-1] ^ s6_tneg;
      end
    end
  end

  // Stage 8: quotient overflow check and divider entry
  wpo_pkg::wpo_div_t div_next;
  wpo_pkg::wpo_div_t s8_div;

  always_comb begin
    div_next.den = s7_den;
    for (int i = 0; i < N; i++) begin
      div_next.lane[i].rem  = REM_W'(s7_mag[i][MAG_W-1:V]);
      div_next.lane[i].bits = s7_mag[i][V-1:0];
      div_next.lane[i].neg  = s7_neg[i];
      div_next.lane[i].ovf  = REM_W'(s7_mag[i][MAG_W-1:V]) >= s7_den;
    end
  end

  always_ff @(posedge clk) begin
    if (r8) begin
      s8_div <= div_next;
    end
  end

  // Divider and result register
  wpo_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v8),
    .in_ready  (div_in_ready),
    .in_data   (s8_div),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/wpo_div_pipe.sv -----
// ----------------------------------------------------------------------------
// wpo_div_pipe: four-lane pipelined restoring divider with output register
// One quotient bit per stage for all lanes against a shared divisor, then
// sign, saturation and the result register with its valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpo_div_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wpo_pkg::wpo_div_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wpo_pkg::wpo_out_t out_data
);

  localparam int V     = wpo_pkg::VAL_BITS;
  localparam int REM_W = wpo_pkg::REM_W;

  // One restoring step on every lane
  function automatic wpo_pkg::wpo_div_t div_step(input wpo_pkg::wpo_div_t d);
    wpo_pkg::wpo_div_t r;
    logic [REM_W:0]    trial;
    logic              qbit;
    r = d;
    for (int i = 0; i < wpo_pkg::LANES; i++) begin
      trial = {d.lane[i].rem, d.lane[i].bits[V-1]};
      qbit  = (trial >= {1'b0, d.den});
      if (qbit) begin
        r.lane[i].rem = REM_W'(trial - {1'b0, d.den});
      end else begin
        r.lane[i].rem = trial[REM_W-1:0];
      end
      r.lane[i].bits = {d.lane[i].bits[V-2:0], qbit};
    end
    return r;
  endfunction

  // Apply sign and saturate one quotient
  function automatic logic signed [V-1:0] finish(input wpo_pkg::wpo_lane_t l);
    logic [V-1:0] q;
    q = l.bits;
    if (l.neg) begin
      if (l.ovf || (q > {1'b1, {(V-1){1'b0}}})) begin
        return wpo_pkg::VAL_MIN;
      end
      return $signed(-q);
    end
    if (l.ovf || q[V-1]) begin
      return wpo_pkg::VAL_MAX;
    end
    return $signed(q);
  endfunction

  logic              dv  [V];
  wpo_pkg::wpo_div_t dd  [V];
  wpo_pkg::wpo_div_t nxt [V];
  logic [V:0]        rdy;

  // Stage ready: a stage loads when empty or when the next one loads
  always_comb begin
    rdy[V] = !out_valid || out_ready;
    for (int j = V - 1; j >= 0; j--) begin
      rdy[j] = !dv[j] || rdy[j+1];
    end
  end

  assign in_ready = rdy[0];

  // Next value of each divider stage
  always_comb begin
    nxt[0] = div_step(in_data);
    for (int j = 1; j < V; j++) begin
      nxt[j] = div_step(dd[j-1]);
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < V; j++) begin
        dv[j] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        dv[0] <= in_valid;
      end
      for (int j = 1; j < V; j++) begin
        if (rdy[j]) begin
          dv[j] <= dv[j-1];
        end
      end
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    for (int j = 0; j < V; j++) begin
      if (rdy[j]) begin
        dd[j] <= nxt[j];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[V]) begin
      out_valid <= dv[V-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[V]) begin
      out_data.flow_east  <= finish(dd[V-1].lane[0]);
      out_data.flow_north <= finish(dd[V-1].lane[1]);
      out_data.flow_west  <= finish(dd[V-1].lane[2]);
      out_data.flow_south <= finish(dd[V-1].lane[3]);
    end
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for water_pipe_outflow_step
// Streams directed and random grid points through the outflow step under
// several coefficient sets, predicts each set of four outflows in the bench
// and checks every result in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int VAL_BITS   = wpo_pkg::VAL_BITS;
  localparam int LANES      = wpo_pkg::LANES;
  localparam int COEF_SHIFT = wpo_pkg::COEF_SHIFT;
  localparam logic signed [VAL_BITS-1:0] VAL_MAX = wpo_pkg::VAL_MAX;
  localparam logic signed [VAL_BITS-1:0] VAL_MIN = wpo_pkg::VAL_MIN;

  // DUT connections; the inputs are known from time zero
  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  wpo_pkg::wpo_in_t              in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  wpo_pkg::wpo_out_t             out_data;
  logic                          cfg_write = 1'b0;
  logic [wpo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wpo_pkg::CFG_W-1:0]     cfg_data  = '0;

  // Coefficients as the block holds them
  longint att_cfg = wpo_pkg::ATT_RESET;
  longint str_cfg = wpo_pkg::STR_RESET;
  longint min_cfg = wpo_pkg::MIN_RESET;

  wpo_pkg::wpo_in_t  pending_points[$];
  wpo_pkg::wpo_out_t expected_flows[$];

  int  send_gap      = 0;
  int  stall_left    = 0;
  bit  tx_steady     = 1'b0;
  bit  rx_steady     = 1'b0;
  bit  hold_request  = 1'b0;
  bit  hold_done     = 1'b0;
  int  mismatches    = 0;
  int  points_taken  = 0;
  int  clears_taken  = 0;
  int  results_seen  = 0;
  int  zero_results  = 0;
  int  n_settings    = 1;

  water_pipe_outflow_step i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp to the signed value range
  function automatic logic signed [VAL_BITS-1:0] sat_val(longint v);
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    if (v < longint'(VAL_MIN)) return VAL_MIN;
    return VAL_BITS'(v);
  endfunction

  // Four new outflows for one grid point under the current coefficients
  function automatic wpo_pkg::wpo_out_t outflow_of(wpo_pkg::wpo_in_t pt);
    longint            level [LANES];
    longint            prior [LANES];
    longint            flow  [LANES];
    longint            centre, depth, total, press;
    wpo_pkg::wpo_out_t res;
    res = '0;
    if (pt.clear) return res;
    depth    = $signed(pt.center_water);
    centre   = longint'($signed(pt.center_terrain)) + depth;
    level[0] = $signed(pt.east_level);
    level[1] = $signed(pt.north_level);
    level[2] = $signed(pt.west_level);
    level[3] = $signed(pt.south_level);
    prior[0] = $signed(pt.old_east);
    prior[1] = $signed(pt.old_north);
    prior[2] = $signed(pt.old_west);
    prior[3] = $signed(pt.old_south);
    total = 0;
    for (int i = 0; i < LANES; i++) begin
      press = centre - level[i];
      if (press < 0) press = 0;
      flow[i] = sat_val((att_cfg * prior[i] + str_cfg * press
                         + (longint'(1) <<< (COEF_SHIFT - 1))) >>> COEF_SHIFT);
      total += flow[i];
    end
    // Cut small totals, scale totals above the water depth
    for (int i = 0; i < LANES; i++) begin
      if (total <= min_cfg) begin
        flow[i] = 0;
      end else if (depth < total) begin
        if (total == 0) flow[i] = 0;
        else flow[i] = sat_val((flow[i] * depth) / total);
      end
    end
    res.flow_east  = VAL_BITS'(flow[0]);
    res.flow_north = VAL_BITS'(flow[1]);
    res.flow_west  = VAL_BITS'(flow[2]);
    res.flow_south = VAL_BITS'(flow[3]);
    return res;
  endfunction

  function automatic int spread(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [VAL_BITS-1:0] corner_val();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return '1;
      4: return VAL_BITS'(1);
      5: return VAL_BITS'($urandom_range(0, 255));
      default: return VAL_BITS'($urandom());
    endcase
  endfunction

  function automatic logic signed [VAL_BITS-1:0] field_val(bit corner);
    if (corner) return corner_val();
    return VAL_BITS'($urandom());
  endfunction

  function automatic wpo_pkg::wpo_in_t make_point(bit clr, longint terrain, longint water,
                                                  longint e, longint n, longint w,
                                                  longint s, longint oe, longint on,
                                                  longint ow, longint os);
    wpo_pkg::wpo_in_t pt;
    pt.clear          = clr;
    pt.center_terrain = VAL_BITS'(terrain);
    pt.center_water   = VAL_BITS'(water);
    pt.east_level     = VAL_BITS'(e);
    pt.north_level    = VAL_BITS'(n);
    pt.west_level     = VAL_BITS'(w);
    pt.south_level    = VAL_BITS'(s);
    pt.old_east       = VAL_BITS'(oe);
    pt.old_north      = VAL_BITS'(on);
    pt.old_west       = VAL_BITS'(ow);
    pt.old_south      = VAL_BITS'(os);
    return pt;
  endfunction

  // Plausible terrain: levels near the centre, modest prior flows, mostly non-negative
  function automatic wpo_pkg::wpo_in_t plain_point();
    wpo_pkg::wpo_in_t pt;
    int               terrain, water, centre, lo_old;
    terrain = spread(-(1 << 20), 3 << 20);
    water   = ($urandom_range(0, 3) == 0) ? spread(0, 1 << 12) : spread(0, 1 << 20);
    centre  = terrain + water;
    lo_old  = ($urandom_range(0, 4) == 0) ? -(1 << 16) : 0;
    pt.clear          = 1'b0;
    pt.center_terrain = VAL_BITS'(terrain);
    pt.center_water   = VAL_BITS'(water);
    pt.east_level     = sat_val(centre + spread(-(1 << 20), 1 << 20));
    pt.north_level    = sat_val(centre + spread(-(1 << 20), 1 << 20));
    pt.west_level     = sat_val(centre + spread(-(1 << 20), 1 << 20));
    pt.south_level    = sat_val(centre + spread(-(1 << 20), 1 << 20));
    pt.old_east       = VAL_BITS'(spread(lo_old, 1 << 19));
    pt.old_north      = VAL_BITS'(spread(lo_old, 1 << 19));
    pt.old_west       = VAL_BITS'(spread(lo_old, 1 << 19));
    pt.old_south      = VAL_BITS'(spread(lo_old, 1 << 19));
    return pt;
  endfunction

  // Mostly plausible points, then raw bits, corner values and clears
  function automatic wpo_pkg::wpo_in_t random_point();
    wpo_pkg::wpo_in_t pt;
    int               r;
    bit               corner;
    r = $urandom_range(0, 99);
    if (r < 60) return plain_point();
    corner = (r >= 75) && (r < 92);
    pt.clear          = (r >= 92) || ($urandom_range(0, 7) == 0);
    pt.center_terrain = field_val(corner);
    pt.center_water   = field_val(corner);
    pt.east_level     = field_val(corner);
    pt.north_level    = field_val(corner);
    pt.west_level     = field_val(corner);
    pt.south_level    = field_val(corner);
    pt.old_east       = field_val(corner);
    pt.old_north      = field_val(corner);
    pt.old_west       = field_val(corner);
    pt.old_south      = field_val(corner);
    return pt;
  endfunction

  task automatic offer_random(int count);
    for (int i = 0; i < count; i++) pending_points.push_back(random_point());
  endtask

  // Wait until nothing is queued, offered or outstanding, then let the pipe empty
  task automatic drain();
    while (pending_points.size() != 0 || in_valid || expected_flows.size() != 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_coefficients(longint att, longint str, longint min_flow);
    drain();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= wpo_pkg::REG_ATTENUATION;
    cfg_data  <= wpo_pkg::CFG_W'(att);
    @(posedge clk);
    cfg_index <= wpo_pkg::REG_STRENGTH;
    cfg_data  <= wpo_pkg::CFG_W'(str);
    @(posedge clk);
    cfg_index <= wpo_pkg::REG_MIN_TOTAL_FLOW;
    cfg_data  <= wpo_pkg::CFG_W'(min_flow);
    @(posedge clk);
    cfg_write <= 1'b0;
    att_cfg = att;
    str_cfg = str;
    min_cfg = min_flow;
    n_settings++;
  endtask

  task automatic compare_flow(string name, logic signed [VAL_BITS-1:0] got,
                              logic signed [VAL_BITS-1:0] want);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: offer queued items, record the expected outflows on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_flows.push_back(outflow_of(in_data));
        points_taken++;
        if (in_data.clear) clears_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          in_data  <= pending_points.pop_front();
          in_valid <= 1'b1;
          send_gap = tx_steady ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expectation, stall at random
  wpo_pkg::wpo_out_t want_flow;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data == '0) zero_results++;
        if (expected_flows.size() == 0) begin
          $error("result with no item outstanding: %h", out_data);
          mismatches++;
        end else begin
          want_flow = expected_flows.pop_front();
          compare_flow("flow_east", out_data.flow_east, want_flow.flow_east);
          compare_flow("flow_north", out_data.flow_north, want_flow.flow_north);
          compare_flow("flow_west", out_data.flow_west, want_flow.flow_west);
          compare_flow("flow_south", out_data.flow_south, want_flow.flow_south);
        end
      end
      // Hold off once for long enough to back the pipe up into the input
      if (hold_request && !hold_done) begin
        stall_left = 200;
        hold_done  = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady) stall_left = pick_gap();
      end
    end
  end

  // Stimulus and phase control
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset coefficients
    pending_points.push_back(make_point(1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
                                        VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX));
    pending_points.push_back(make_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_points.push_back(make_point(0, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
                                        VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX));
    pending_points.push_back(make_point(0, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
                                        VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN));
    // saturated flows scaled down to the depth, then a negative total cut to zero
    pending_points.push_back(make_point(0, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN,
                                        VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX));
    pending_points.push_back(make_point(0, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX,
                                        VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN));
    // total exactly at the minimum, then one above it
    pending_points.push_back(make_point(0, 0, 1 << 20, (1 << 20) - 420, 1 << 22, 1 << 22,
                                        1 << 22, 0, 0, 0, 0));
    pending_points.push_back(make_point(0, 0, 1 << 20, (1 << 20) - 424, 1 << 22, 1 << 22,
                                        1 << 22, 0, 0, 0, 0));
    // total equal to the depth, then one above it
    pending_points.push_back(make_point(0, 0, 1000, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_points.push_back(make_point(0, 1, 999, 0, 0, 0, 0, 0, 0, 0, 0));
    // negative water depth taken as is
    pending_points.push_back(make_point(0, VAL_MAX, -4096, 0, 0, 0, 0, 0, 0, 0, 0));
    // pressure in one direction at a time
    pending_points.push_back(make_point(0, 0, 1 << 20, 0, 1 << 22, 1 << 22, 1 << 22,
                                        1 << 16, 0, 0, 0));
    pending_points.push_back(make_point(0, 0, 1 << 20, 1 << 22, 0, 1 << 22, 1 << 22,
                                        0, 1 << 16, 0, 0));
    pending_points.push_back(make_point(0, 0, 1 << 20, 1 << 22, 1 << 22, 0, 1 << 22,
                                        0, 0, 1 << 16, 0));
    pending_points.push_back(make_point(0, 0, 1 << 20, 1 << 22, 1 << 22, 1 << 22, 0,
                                        0, 0, 0, 1 << 16));
    // prior flows of both signs
    pending_points.push_back(make_point(0, 1 << 20, 1 << 20, 0, 0, 0, 0,
                                        VAL_MAX, VAL_MIN, 1 << 20, -(1 << 20)));
    offer_random(50);

    // Full retention, no gain, zero minimum: mixed signs overflow on scaling
    load_coefficients(65536, 0, 0);
    pending_points.push_back(make_point(0, 0, -2, 0, 0, 0, 0,
                                        VAL_MAX, longint'(VAL_MIN) + 2, 0, 0));
    offer_random(100);

    // Upper ends of gain and retention, lowest minimum
    load_coefficients(65536, 65536, -1048576);
    pending_points.push_back(make_point(0, 0, -8, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_points.push_back(make_point(0, 0, -5000, 0, 0, 0, 0,
                                        -1000, -1000, -1000, -1000));
    offer_random(150);

    // Lower ends of gain and retention, highest minimum, no idling
    load_coefficients(0, -65536, 1048576);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    offer_random(100);

    for (int k = 0; k < 3; k++) begin
      load_coefficients(spread(0, 65536), spread(-65536, 65536),
                        spread(-1048576, 1048576));
      tx_steady = (k == 1);
      rx_steady = 1'b0;
      offer_random(150);
    end

    // Back to defaults; long receiver hold, then a sender pause mid-stream
    load_coefficients(wpo_pkg::ATT_RESET, wpo_pkg::STR_RESET, wpo_pkg::MIN_RESET);
    tx_steady    = 1'b0;
    hold_request = 1'b1;
    offer_random(175);
    drain();
    offer_random(175);
    drain();

    $display("Checked %0d outflow results from %0d cells (%0d cleared, %0d all zero)",
             results_seen, points_taken, clears_taken, zero_results);
    $display("Coefficient sets used: %0d, both ends of every register range included",
             n_settings);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $error("run did not finish in time, %0d results outstanding", expected_flows.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/wpo_pkg.sv
src/wpo_div_pipe.sv
src/water_pipe_outflow_step.sv
test/tb_top.sv
